// ===== src/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg
// Shared widths, register indexes, reset values and controller/datapath types
// for the scalar Kalman filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 4;
	localparam int GAIN_FRAC = 24;
	localparam int GAIN_W    = GAIN_FRAC + 1;
	localparam int DIV_STEPS = GAIN_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = CFG_IDX_W'(1);

	// reset values, unsigned Q8.24
	localparam logic [DATA_W-1:0] Q_RESET = 32'd1678;
	localparam logic [DATA_W-1:0] R_RESET = 32'd83886;
	localparam logic [DATA_W-1:0] P_RESET = 32'd167772160;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

	typedef struct packed {
		logic load;
		logic prep;
		logic div_step;
		logic mul_corr;
		logic mul_cov;
		logic commit;
	} skf_cmd_t;

	typedef struct packed {
		logic denom_zero;
	} skf_status_t;

endpackage

`default_nettype wire

// ===== src/skf_if.sv =====
// ----------------------------------------------------------------------------
// skf channel interfaces
// Valid/ready channels for measurement words, estimate words and register
// writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface skf_meas_if;
	import skf_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] measurement;

	modport source (output valid, output measurement, input ready);
	modport sink   (input valid, input measurement, output ready);
endinterface

interface skf_est_if;
	import skf_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] estimate;

	modport source (output valid, output estimate, input ready);
	modport sink   (input valid, input estimate, output ready);
endinterface

interface skf_cfg_if;
	import skf_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/skf_ctrl.sv =====
// ----------------------------------------------------------------------------
// skf_ctrl
// Sequencer for one filter update: load, prepare, divide, two multiplies and
// hand-over to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output skf_pkg::skf_cmd_t         cmd,
	input  wire skf_pkg::skf_status_t status
);
	import skf_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_MCORR = 3'd3;
	localparam logic [2:0] ST_MCOV  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]           state_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	logic                 slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.prep     = (state_q == ST_PREP);
		cmd.div_step = (state_q == ST_DIV) && !status.denom_zero;
		cmd.mul_corr = (state_q == ST_MCORR);
		cmd.mul_cov  = (state_q == ST_MCOV);
		cmd.commit   = (state_q == ST_FIN) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// zero denominator leaves the gain at zero
					if (status.denom_zero || cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
						state_q <= ST_MCORR;
					cnt_q <= cnt_q + DIV_CNT_W'(1);
				end
				ST_MCORR: state_q <= ST_MCOV;
				ST_MCOV:  state_q <= ST_FIN;
				ST_FIN: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/skf_dp.sv =====
// ----------------------------------------------------------------------------
// skf_dp
// Filter datapath: noise registers, filter state, restoring divider for the
// gain and one shared signed multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire skf_pkg::skf_cmd_t           cmd,
	output skf_pkg::skf_status_t             status,
	input  wire logic                        cfg_we,
	input  wire logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [skf_pkg::DATA_W-1:0]  cfg_data,
	input  wire logic signed [skf_pkg::DATA_W-1:0] measurement,
	output logic signed [skf_pkg::DATA_W-1:0] estimate
);
	import skf_pkg::*;

	localparam int DIFF_W = DATA_W + 1;
	localparam int REM_W  = DATA_W + 2;
	localparam int MUL_AW = GAIN_W + 1;
	localparam int PROD_W = MUL_AW + DIFF_W;
	localparam int CORR_W = PROD_W - GAIN_FRAC;
	localparam int EST_W  = CORR_W + 1;

	localparam logic signed [EST_W-1:0] EST_MAX = EST_W'(32'sh7FFF_FFFF);
	localparam logic signed [EST_W-1:0] EST_MIN = -EST_W'(64'sh8000_0000);

	logic [DATA_W-1:0]        q_q, r_q, p_q;
	logic signed [DATA_W-1:0] prior_q, meas_q, est_q, out_q;
	logic [DATA_W-1:0]        p1_q;
	logic [DATA_W:0]          denom_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic [REM_W-1:0]         rem_q;
	logic [GAIN_W-1:0]        gain_q;
	logic signed [PROD_W-1:0] prod_q;

	logic [DATA_W:0]          p_sum;
	logic                     div_ge;
	logic [REM_W-1:0]         rem_sub;
	logic signed [MUL_AW-1:0] mul_a;
	logic signed [DIFF_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [CORR_W-1:0] corr;
	logic signed [EST_W-1:0]  est_wide;
	logic signed [DATA_W-1:0] est_sat;

	assign status.denom_zero = (denom_q == '0);
	assign estimate          = out_q;

	assign p_sum = {1'b0, p_q} + {1'b0, q_q};

	// one restoring step: quotient bits leave msb first
	assign div_ge  = (rem_q >= {1'b0, denom_q});
	assign rem_sub = div_ge ? (rem_q - {1'b0, denom_q}) : rem_q;

	// shared multiplier: gain*diff, then (1-gain)*p1
	assign mul_a = cmd.mul_cov ? $signed({1'b0, GAIN_ONE - gain_q})
	                           : $signed({1'b0, gain_q});
	assign mul_b = cmd.mul_cov ? $signed({1'b0, p1_q}) : diff_q;
	assign mul_p = mul_a * mul_b;

	// arithmetic shift rounds toward minus infinity
	assign corr     = prod_q[PROD_W-1:GAIN_FRAC];
	assign est_wide = EST_W'(prior_q) + EST_W'(corr);

	always_comb begin
		if (est_wide > EST_MAX)
			est_sat = 32'sh7FFF_FFFF;
		else if (est_wide < EST_MIN)
			est_sat = 32'sh8000_0000;
		else
			est_sat = est_wide[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q     <= Q_RESET;
			r_q     <= R_RESET;
			p_q     <= P_RESET;
			prior_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PROCESS_NOISE: q_q <= cfg_data;
					REG_MEASURE_NOISE: r_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.mul_cov)
				p_q <= mul_p[GAIN_FRAC +: DATA_W];
			if (cmd.commit)
				prior_q <= est_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			meas_q <= measurement;
			p1_q   <= p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];
		end
		if (cmd.prep) begin
			denom_q <= {1'b0, p1_q} + {1'b0, r_q};
			diff_q  <= DIFF_W'(meas_q) - DIFF_W'(prior_q);
			rem_q   <= REM_W'(p1_q);
			gain_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= {rem_sub[REM_W-2:0], 1'b0};
			gain_q <= {gain_q[GAIN_W-2:0], div_ge};
		end
		if (cmd.mul_corr)
			prod_q <= mul_p;
		if (cmd.mul_cov)
			est_q <= est_sat;
		if (cmd.commit)
			out_q <= est_q;
	end

endmodule

`default_nettype wire

// ===== src/scalar_kalman_filter_core.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core
// One-dimensional Kalman filter on signed Q16.16 samples with programmable
// process and measurement noise.
// ----------------------------------------------------------------------------
// Each measurement word updates the covariance (P += q, saturating), forms
// the gain P/(P+r) in Q1.24 with a restoring divider, corrects the estimate
// and shrinks P by (1 - gain); one estimate word is produced per measurement.
// The estimate word appears after load, prepare, the 25 iterations of the
// divider, two multiplies and hand-over; with a zero denominator the divider
// makes no step and the update goes straight on to the multiplies.
// A stalled estimate word holds the update in its last step until it is taken.
// Only one measurement is in flight at a time; the next is taken as soon as
// the previous estimate sits in the output register, even if not yet taken.
// Register writes (index 0 process noise, index 1 measurement noise, both
// unsigned Q8.24) are always accepted and belong in idle periods; other
// indexes are ignored.
`default_nettype none

module scalar_kalman_filter_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	skf_meas_if.sink   sample,
	skf_est_if.source  result,
	skf_cfg_if.sink    cfg
);
	import skf_pkg::*;

	skf_cmd_t    cmd;
	skf_status_t status;

	// register writes never stall
	assign cfg.ready = 1'b1;

	// sequencer: owns the measurement and estimate handshakes and the output word valid
	skf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// datapath: filter state, divider and shared multiplier
	skf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.measurement (sample.measurement),
		.estimate    (result.estimate)
	);

`ifndef SYNTHESIS
	// one word in flight: after an accept the input closes
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> !sample.ready)
		else $error("second measurement word taken during an update");

	// divider never steps on a zero denominator
	a_no_div_by_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !status.denom_zero)
		else $error("divider stepped with zero denominator");

	// a new estimate only appears after an update has run
	a_out_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.commit))
		else $error("estimate word appeared without a commit");

	// commit never coincides with a load or a divider step
	a_commit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !cmd.load && !cmd.div_step)
		else $error("commit overlaps another step");
`endif

endmodule

`default_nettype wire

// ===== tb/skf_checker.sv =====
// ----------------------------------------------------------------------------
// skf_checker
// Watches the measurement, estimate and register channels of the scalar
// Kalman filter, predicts every estimate word and compares it as it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skf_checker (
	input  logic clk,
	input  logic arst_n,
	skf_meas_if  sample,
	skf_est_if   result,
	skf_cfg_if   cfg,
	output int   fail_count,
	output int   pending_count,
	output int   checked_count
);
	import skf_pkg::*;

	// filter state as the block should hold it
	logic [DATA_W-1:0]        q_noise;
	logic [DATA_W-1:0]        r_noise;
	logic [DATA_W-1:0]        cov_state;
	logic signed [DATA_W-1:0] est_state;

	logic signed [DATA_W-1:0] predicted_estimates[$];
	logic signed [DATA_W-1:0] want;

	// one filter update, advancing cov_state and est_state
	function automatic void kalman_step(input logic signed [DATA_W-1:0] meas);
		logic [DATA_W:0]         p1_wide;
		logic [DATA_W-1:0]       p1;
		logic [DATA_W:0]         denom;
		logic [DATA_W+GAIN_W-1:0] quot;
		logic [GAIN_W-1:0]       gain;
		logic [GAIN_W-1:0]       keep;
		logic [63:0]             cov_prod;
		longint                  diff;
		longint                  corr;
		longint                  sum;

		// covariance grows by q, clipped at full scale
		p1_wide = {1'b0, cov_state} + {1'b0, q_noise};
		p1      = p1_wide[DATA_W] ? '1 : p1_wide[DATA_W-1:0];

		denom = {1'b0, p1} + {1'b0, r_noise};
		if (denom == '0) begin
			gain = '0;
		end else begin
			quot = ({{GAIN_W{1'b0}}, p1} << GAIN_FRAC) / {{(GAIN_W-1){1'b0}}, denom};
			gain = (quot > GAIN_ONE) ? GAIN_ONE : quot[GAIN_W-1:0];
		end

		// arithmetic shift of a signed product floors toward minus infinity
		diff = longint'(meas) - longint'(est_state);
		corr = (longint'({{(64-GAIN_W){1'b0}}, gain}) * diff) >>> GAIN_FRAC;
		sum  = longint'(est_state) + corr;
		if (sum > longint'(32'sh7FFF_FFFF))
			sum = longint'(32'sh7FFF_FFFF);
		if (sum < longint'(32'sh8000_0000))
			sum = longint'(32'sh8000_0000);
		est_state = sum[DATA_W-1:0];

		keep      = GAIN_ONE - gain;
		cov_prod  = {{(64-GAIN_W){1'b0}}, keep} * {32'd0, p1};
		cov_state = cov_prod[GAIN_FRAC +: DATA_W];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise       = Q_RESET;
			r_noise       = R_RESET;
			cov_state     = P_RESET;
			est_state     = '0;
			predicted_estimates.delete();
			fail_count    = 0;
			pending_count = 0;
			checked_count = 0;
		end else begin
			// retire first, so a word taken on the same edge as a new sample
			// is matched against the older prediction
			if (result.valid && result.ready) begin
				if (predicted_estimates.size() == 0) begin
					$error("estimate word with nothing outstanding: got %0d",
						result.estimate);
					fail_count++;
				end else begin
					want = predicted_estimates.pop_front();
					checked_count++;
					if (result.estimate !== want) begin
						$error("estimate mismatch: expected %0d, actual %0d",
							want, result.estimate);
						fail_count++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_PROCESS_NOISE: q_noise = cfg.data;
					REG_MEASURE_NOISE: r_noise = cfg.data;
					default: ;
				endcase
			end
			if (sample.valid && sample.ready) begin
				kalman_step(sample.measurement);
				predicted_estimates.push_back(est_state);
			end
			pending_count = predicted_estimates.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the scalar Kalman filter core: directed corner
// cases, then noisy tracking signals under many noise settings, with random
// gaps on the measurement side and random stalls on the estimate side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import skf_pkg::*;

	// roughly 1025 words, each with its worst gap and stall, stay well inside the limit
	localparam int CYCLE_LIMIT      = 1_000_000;
	localparam int RANDOM_SEGMENTS  = 20;
	localparam int SEGMENT_WORDS    = 50;
	localparam int QUIET_SEGMENTS   = 3;
	localparam int DRAIN_CYCLES     = 40;
	localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = REG_MEASURE_NOISE + 1'b1;
	localparam logic signed [DATA_W-1:0] MEAS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] MEAS_MIN = 32'sh8000_0000;
	localparam logic [DATA_W-1:0] NOISE_MAX = 32'hFFFF_FFFF;

	logic clk;
	logic arst_n;

	skf_meas_if meas_ch ();
	skf_est_if  est_ch ();
	skf_cfg_if  cfg_ch ();

	scalar_kalman_filter_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (meas_ch),
		.result (est_ch),
		.cfg    (cfg_ch)
	);

	int fail_count;
	int pending_count;
	int checked_count;

	skf_checker filter_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample        (meas_ch),
		.result        (est_ch),
		.cfg           (cfg_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	// idling odds: 0 means none, otherwise a burst starts one time in n
	int send_gap_odds;
	int take_stall_odds;
	int sent_count;
	int write_count;
	int setting_count;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop, whatever the stimulus is doing
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d estimate words outstanding",
				cycle_count, pending_count);
			$display("FAIL scalar_kalman_filter_core");
			$finish;
		end
	end

	// estimate side: ready high, broken by random stall bursts
	initial begin
		est_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (take_stall_odds != 0 && $urandom_range(1, take_stall_odds) == 1) begin
				est_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 13) - 1) @(negedge clk);
			end else begin
				est_ch.ready <= 1'b1;
			end
		end
	end

	// offers one measurement word, called at a falling edge and returning at
	// the falling edge after acceptance with valid still high
	task automatic send_measurement(input logic signed [DATA_W-1:0] meas);
		if (send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
			meas_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		meas_ch.valid       <= 1'b1;
		meas_ch.measurement <= meas;
		@(posedge clk);
		while (!meas_ch.ready) @(posedge clk);
		@(negedge clk);
		sent_count++;
	endtask

	// one register word; valid is left high for the caller to drop
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		write_count++;
	endtask

	// stop the sample stream, let every estimate come back, then reprogram
	// both noise registers and maybe poke an unused index
	task automatic set_noise(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] r,
			input bit poke_unused);
		meas_ch.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		write_register(REG_PROCESS_NOISE, q);
		write_register(REG_MEASURE_NOISE, r);
		if (poke_unused)
			write_register(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, 2**CFG_IDX_W - 1)),
				$urandom);
		cfg_ch.valid <= 1'b0;
		setting_count++;
	endtask

	function automatic logic [DATA_W-1:0] pick_noise();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return NOISE_MAX;
			2:       return DATA_W'($urandom_range(0, 2**20));
			3:       return $urandom;
			4:       return $urandom_range(0, 1) ? Q_RESET : R_RESET;
			default: return 32'h0100_0000 + $urandom_range(0, 2**24) - 2**23;
		endcase
	endfunction

	function automatic int pick_odds();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 3;
			default: return 10;
		endcase
	endfunction

	initial begin
		logic signed [DATA_W-1:0] level;
		logic signed [DATA_W-1:0] meas;
		int                       spread;

		arst_n              = 1'b0;
		meas_ch.valid       = 1'b0;
		meas_ch.measurement = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		send_gap_odds       = 0;
		take_stall_odds     = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// reset noise values: full-scale swings from the large initial P
		send_measurement(MEAS_MAX);
		send_measurement(MEAS_MIN);
		send_measurement('0);
		send_measurement(32'sd1);
		send_measurement(-32'sd1);
		send_measurement(32'sh0001_0000);
		send_measurement(MEAS_MAX);
		send_measurement(MEAS_MIN);

		// r = 0 gives unit gain, then q = r = 0 with P at zero hits the
		// zero-denominator path and the estimate must hold
		set_noise('0, '0, 1'b1);
		send_measurement(32'sd12345);
		send_measurement(MEAS_MIN);
		send_measurement(MEAS_MAX);

		// both noises at full scale: P + q clips
		set_noise(NOISE_MAX, NOISE_MAX, 1'b0);
		send_measurement(MEAS_MAX);
		send_measurement(MEAS_MIN);
		send_measurement(MEAS_MIN);
		send_measurement(MEAS_MAX);

		// clipped P with no measurement noise, exact unit gain
		set_noise(NOISE_MAX, '0, 1'b0);
		send_measurement(MEAS_MAX);
		send_measurement(MEAS_MIN);

		// P at zero, huge r: gain rounds to nothing
		set_noise('0, NOISE_MAX, 1'b1);
		send_measurement(32'sh4000_0000);
		send_measurement(-32'sh4000_0000);

		set_noise(Q_RESET, R_RESET, 1'b0);
		send_measurement(32'sh0003_8000);
		send_measurement(-32'sh0002_4000);

		// random part: each segment picks a noise setting, idling odds and a
		// tracking level; most words are that level plus bounded noise
		for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
			set_noise(pick_noise(), pick_noise(), $urandom_range(0, 3) == 0);
			if (seg >= RANDOM_SEGMENTS - QUIET_SEGMENTS) begin
				send_gap_odds   = 0;
				take_stall_odds = 0;
			end else begin
				send_gap_odds   = pick_odds();
				take_stall_odds = pick_odds();
			end
			level  = $urandom;
			spread = 1 << $urandom_range(4, 24);
			for (int n = 0; n < SEGMENT_WORDS; n++) begin
				case ($urandom_range(0, 19))
					0, 1, 2: meas = $urandom;
					3:       meas = $urandom_range(0, 1) ? MEAS_MAX : MEAS_MIN;
					default: begin
						// slow drift of the level plus sample noise
						level = level + DATA_W'($urandom_range(0, 64)) - 32;
						meas  = level + DATA_W'($urandom_range(0, 2 * spread)) - spread;
					end
				endcase
				send_measurement(meas);
			end
		end

		meas_ch.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		// catch any stray extra words the block might still emit
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d measurement words filtered, %0d estimates checked", sent_count,
			checked_count);
		$display("%0d register writes across %0d noise settings", write_count,
			setting_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("PASS scalar_kalman_filter_core");
		end else begin
			$display("FAIL scalar_kalman_filter_core");
		end
		$finish;
	end

endmodule
